// File: src/tpsc_pkg.sv
// Shared types and constants for the tempo phase sync controller.
// No dependencies; imported by every module in src.
package tpsc_pkg;

	// sync_state codes
	localparam logic [1:0] ST_OFF    = 2'd0;
	localparam logic [1:0] ST_INIT   = 2'd1;
	localparam logic [1:0] ST_LOCKED = 2'd2;
	localparam logic [1:0] ST_DRIFT  = 2'd3;

	// opcodes
	localparam logic [1:0] OP_UPDATE  = 2'd0;
	localparam logic [1:0] OP_ENABLE  = 2'd1;
	localparam logic [1:0] OP_DISABLE = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_CHECK_INTERVAL  = 3'd0;
	localparam logic [2:0] REG_DRIFT_LIMIT     = 3'd1;
	localparam logic [2:0] REG_SETTLE_UPDATES  = 3'd2;
	localparam logic [2:0] REG_BPM_TOLERANCE   = 3'd3;
	localparam logic [2:0] REG_STABILITY_COUNT = 3'd4;

	// register reset values
	localparam logic [19:0] CHECK_INTERVAL_RST  = 20'd88200;
	localparam logic [15:0] DRIFT_LIMIT_RST     = 16'd50;
	localparam logic [15:0] SETTLE_UPDATES_RST  = 16'd1000;
	localparam logic [9:0]  BPM_TOLERANCE_RST   = 10'd10;
	localparam logic [15:0] STABILITY_COUNT_RST = 16'd4;

	// counter limits
	localparam logic [19:0] CNT_MAX  = 20'hFFFFF;
	localparam logic [15:0] STAB_MAX = 16'hFFFF;

	// divider geometry: (tgt*20000 + own) / (2*own)
	localparam int DIV_NW = 32;
	localparam int DIV_DW = 18;

	// fixed point scale: 1.0 = 10000, +-50% clamp
	localparam logic [14:0] UNITY      = 15'd10000;
	localparam logic [14:0] UNITY_X2   = 15'd20000;
	localparam logic [13:0] UNITY_14   = 14'd10000;
	localparam logic [31:0] Q_HI       = 32'd15000;
	localparam logic [31:0] Q_LO       = 32'd5000;
	localparam logic signed [13:0] TEMPO_MAX = 14'sd5000;
	localparam logic signed [13:0] TEMPO_MIN = -14'sd5000;

	typedef logic signed [13:0] tempo_t;

endpackage

// File: src/tpsc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tpsc_pkg only through the import.
module tpsc_div
	import tpsc_pkg::*;
#(
	parameter int NW = 32,
	parameter int DW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CW = $clog2(NW);
	localparam logic [CW-1:0] LAST = CW'(NW - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic          ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the low end of the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// File: src/tempo_phase_sync_controller_unit.sv
// Tempo phase sync controller top level: APB register file, sequencer, result register.
// Depends on tpsc_pkg and tpsc_div.
//
// One word in, one result word out. For enable, disable and updates outside the
// initializing state, the word passes through the execute and finish states, and the
// result is registered when it leaves finish. An update while initializing needs the
// tempo ratio and runs the radix-2 divider between execute and finish (a zero own
// tempo skips the divider). The block takes one word at a time; a finished result
// sits in the output register and the next word is accepted while it waits, but
// that word does not finish until the result has been taken. Registers are to be
// written through APB only while idle; the block itself does not enforce this.
module tempo_phase_sync_controller_unit
	import tpsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic               target_present,
	input  logic [16:0]        target_bpm,
	input  logic [16:0]        own_bpm,
	input  logic signed [13:0] current_tempo,
	input  logic signed [23:0] phase_offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         sync_state,
	output logic               is_locked,
	output logic               ramp_write,
	output logic signed [13:0] ramp_target,
	output logic               tempo_write,
	output logic signed [13:0] tempo_value
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	// config registers
	logic [19:0] chk_q;
	logic [15:0] lim_q;
	logic [15:0] settle_q;
	logic [9:0]  tol_q;
	logic [15:0] stabc_q;

	// control state
	logic [1:0]  st_q;
	logic [1:0]  mode_q;
	logic [19:0] cnt_q;
	logic [15:0] stab_q;
	logic        out_valid_q;

	// latched word
	logic [1:0]   op_q;
	logic         pres_q;
	logic [16:0]  tgt_q;
	logic [16:0]  own_q;
	tempo_t       ct_q;
	logic [23:0]  ph_q;

	// lock test operands
	logic [31:0] p1_q;
	logic [30:0] p2_q;
	logic [23:0] tol10k_q;

	// result registers
	logic [1:0] sync_state_q;
	logic       is_locked_q;
	logic       ramp_write_q;
	tempo_t     ramp_target_q;
	logic       tempo_write_q;
	tempo_t     tempo_value_q;

	logic        cfg_wr;
	logic        accept;
	logic        need_div;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_num;
	logic [31:0] quot;
	logic [14:0] eff;
	logic        commit;

	logic [1:0]  mode_n;
	logic [19:0] cnt_n;
	logic [15:0] stab_n;
	logic [19:0] cnt_inc;
	logic        rw;
	tempo_t      rt;
	logic        tw;
	tempo_t      tv;
	logic [23:0] aph;
	logic        over_lim;
	logic        under_lim;
	logic signed [32:0] diff;
	logic [32:0] adiff;
	logic        lock_hit;
	logic signed [14:0] nudged;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q    <= CHECK_INTERVAL_RST;
			lim_q    <= DRIFT_LIMIT_RST;
			settle_q <= SETTLE_UPDATES_RST;
			tol_q    <= BPM_TOLERANCE_RST;
			stabc_q  <= STABILITY_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_CHECK_INTERVAL:  chk_q    <= pwdata[19:0];
				REG_DRIFT_LIMIT:     lim_q    <= pwdata[15:0];
				REG_SETTLE_UPDATES:  settle_q <= pwdata[15:0];
				REG_BPM_TOLERANCE:   tol_q    <= pwdata[9:0];
				REG_STABILITY_COUNT: stabc_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_CHECK_INTERVAL:  prdata = {12'd0, chk_q};
			REG_DRIFT_LIMIT:     prdata = {16'd0, lim_q};
			REG_SETTLE_UPDATES:  prdata = {16'd0, settle_q};
			REG_BPM_TOLERANCE:   prdata = {22'd0, tol_q};
			REG_STABILITY_COUNT: prdata = {16'd0, stabc_q};
			default:             prdata = '0;
		endcase
	end

	// sequencer
	assign in_ready  = (st_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign need_div  = (op_q == OP_UPDATE) && (mode_q == ST_INIT) && (own_q != 17'd0);
	assign div_start = (st_q == S_EXEC) && need_div;
	assign commit    = (st_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			unique case (st_q)
				S_IDLE: if (accept) st_q <= S_EXEC;
				S_EXEC: st_q <= need_div ? S_DIV : S_FIN;
				S_DIV:  if (div_done) st_q <= S_FIN;
				S_FIN:  if (commit) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			pres_q <= target_present;
			tgt_q  <= target_bpm;
			own_q  <= own_bpm;
			ct_q   <= current_tempo;
			ph_q   <= phase_offset;
		end
	end

	// effective tempo scale 10000 + ct, always positive
	assign eff     = {ct_q[13], ct_q} + UNITY;
	assign div_num = ({15'd0, tgt_q} * {17'd0, UNITY_X2}) + {15'd0, own_q};

	always_ff @(posedge clk) begin
		if (st_q == S_EXEC) begin
			p1_q     <= {15'd0, own_q} * {17'd0, eff};
			p2_q     <= 31'({14'd0, tgt_q} * {16'd0, UNITY});
			tol10k_q <= 24'({14'd0, tol_q} * {9'd0, UNITY});
		end
	end

	tpsc_div #(
		.NW(DIV_NW),
		.DW(DIV_DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   ({own_q, 1'b0}),
		.done  (div_done),
		.quot  (quot)
	);

	// next-state and result
	assign cnt_inc   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 20'd1;
	assign aph       = ph_q[23] ? (~ph_q + 24'd1) : ph_q;
	assign over_lim  = aph > {8'd0, lim_q};
	assign under_lim = aph < {8'd0, lim_q};
	assign diff      = $signed({1'b0, p1_q}) - $signed({2'b0, p2_q});
	assign adiff     = diff[32] ? 33'(-diff) : 33'(diff);
	assign lock_hit  = adiff < {9'd0, tol10k_q};
	assign nudged    = $signed({ct_q[13], ct_q}) + (ph_q[23] ? -15'sd1 : 15'sd1);

	always_comb begin
		if (own_q == 17'd0 || quot > Q_HI) begin
			rt = TEMPO_MAX;
		end else if (quot < Q_LO) begin
			rt = TEMPO_MIN;
		end else begin
			rt = tempo_t'(quot[13:0] - UNITY_14);
		end
		if (nudged > 15'sd5000) begin
			tv = TEMPO_MAX;
		end else if (nudged < -15'sd5000) begin
			tv = TEMPO_MIN;
		end else begin
			tv = nudged[13:0];
		end
	end

	always_comb begin
		mode_n = mode_q;
		cnt_n  = cnt_q;
		stab_n = stab_q;
		rw     = 1'b0;
		tw     = 1'b0;
		if (op_q == OP_ENABLE && pres_q) begin
			mode_n = ST_INIT;
			cnt_n  = '0;
			stab_n = '0;
		end else if (op_q == OP_DISABLE || op_q == OP_ENABLE) begin
			mode_n = ST_OFF;
			cnt_n  = '0;
			stab_n = '0;
		end else if (op_q == OP_UPDATE) begin
			unique case (mode_q)
				ST_INIT: begin
					rw    = 1'b1;
					cnt_n = cnt_inc;
					if (lock_hit) begin
						mode_n = ST_LOCKED;
						stab_n = '0;
					end
				end
				ST_LOCKED: begin
					cnt_n = cnt_inc;
					if (cnt_inc >= chk_q) begin
						cnt_n = '0;
						if (over_lim) begin
							mode_n = ST_DRIFT;
							stab_n = '0;
						end else if (stab_q != STAB_MAX) begin
							stab_n = stab_q + 16'd1;
						end
					end
				end
				ST_DRIFT: begin
					cnt_n = cnt_inc;
					tw    = over_lim;
					// relock needs the phase strictly inside the limit
					if (under_lim && cnt_inc > {4'd0, settle_q}) begin
						mode_n = ST_LOCKED;
						stab_n = '0;
						cnt_n  = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ST_OFF;
			cnt_q       <= '0;
			stab_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				mode_q <= mode_n;
				cnt_q  <= cnt_n;
				stab_q <= stab_n;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			sync_state_q  <= mode_n;
			is_locked_q   <= (mode_n == ST_LOCKED) && (stab_n >= stabc_q);
			ramp_write_q  <= rw;
			ramp_target_q <= rw ? rt : '0;
			tempo_write_q <= tw;
			tempo_value_q <= tw ? tv : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign sync_state  = sync_state_q;
	assign is_locked   = is_locked_q;
	assign ramp_write  = ramp_write_q;
	assign ramp_target = ramp_target_q;
	assign tempo_write = tempo_write_q;
	assign tempo_value = tempo_value_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == S_DIV)
		else $error("divider finished outside the divide step");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(ramp_write && tempo_write))
		else $error("ramp and tempo writes in one word");

	a_ramp_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ramp_write) |-> (sync_state == ST_INIT || sync_state == ST_LOCKED))
		else $error("ramp write outside initializing");

	a_tempo_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tempo_write) |-> (sync_state == ST_DRIFT || sync_state == ST_LOCKED))
		else $error("tempo write outside drifting");

	a_locked_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_locked) |-> sync_state == ST_LOCKED)
		else $error("locked flag without locked state");

endmodule

// File: test/tb_tempo_phase_sync_controller_unit.sv
// Testbench for tempo_phase_sync_controller_unit: directed and random command words
// checked field by field against an in-bench sync state predictor.
// Depends on tpsc_pkg and the RTL in src.
module tb_tempo_phase_sync_controller_unit;
	import tpsc_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_LEN     = 500;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_WORDS  = 272;

	typedef struct {
		logic [1:0]         op;
		logic               present;
		logic [16:0]        tgt;
		logic [16:0]        own;
		logic signed [13:0] ct;
		logic signed [23:0] ph;
	} sync_word_t;

	typedef struct {
		logic [1:0]         state;
		logic               locked;
		logic               ramp_wr;
		logic signed [13:0] ramp;
		logic               tempo_wr;
		logic signed [13:0] tempo;
	} sync_result_t;

	typedef struct {
		logic [19:0] check_interval;
		logic [15:0] drift_limit;
		logic [15:0] settle_updates;
		logic [9:0]  bpm_tolerance;
		logic [15:0] stability_count;
	} sync_cfg_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode = OP_UPDATE;
	logic               target_present = 1'b0;
	logic [16:0]        target_bpm = '0;
	logic [16:0]        own_bpm = '0;
	logic signed [13:0] current_tempo = '0;
	logic signed [23:0] phase_offset = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         sync_state;
	logic               is_locked;
	logic               ramp_write;
	logic signed [13:0] ramp_target;
	logic               tempo_write;
	logic signed [13:0] tempo_value;

	tempo_phase_sync_controller_unit DUT (.*);

	// predictor state and register copy
	logic [1:0]  trk_mode = ST_OFF;
	logic [19:0] trk_since_adjust = '0;
	logic [15:0] trk_stable = '0;
	sync_cfg_t   cfg = '{CHECK_INTERVAL_RST, DRIFT_LIMIT_RST, SETTLE_UPDATES_RST,
		BPM_TOLERANCE_RST, STABILITY_COUNT_RST};

	sync_word_t   pending_words[$];
	sync_result_t expected_results[$];
	sync_word_t   drive_word;
	int           words_queued = 0;
	int           words_accepted = 0;
	int           fail_cnt = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;
	int           hold_left = 0;
	bit           hold_done = 1'b0;
	int           cycle_cnt = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint clamp_tempo(input longint v);
		if (v > 5000)
			return 5000;
		if (v < -5000)
			return -5000;
		return v;
	endfunction

	function automatic void bump_since_adjust();
		if (trk_since_adjust != CNT_MAX)
			trk_since_adjust++;
	endfunction

	function automatic sync_result_t predict_sync_result(input sync_word_t w);
		sync_result_t r;
		longint tgt, own, ct, ph, aph, lim, diff, q;
		tgt = w.tgt;
		own = w.own;
		ct = w.ct;
		ph = w.ph;
		aph = (ph < 0) ? -ph : ph;
		lim = cfg.drift_limit;
		r.ramp_wr = 1'b0;
		r.ramp = '0;
		r.tempo_wr = 1'b0;
		r.tempo = '0;
		if (w.op == OP_ENABLE && w.present) begin
			trk_mode = ST_INIT;
			trk_since_adjust = '0;
			trk_stable = '0;
		end else if (w.op == OP_ENABLE || w.op == OP_DISABLE) begin
			// enable with no target deck behaves as disable
			trk_mode = ST_OFF;
			trk_since_adjust = '0;
			trk_stable = '0;
		end else if (w.op == OP_UPDATE) begin
			case (trk_mode)
				ST_INIT: begin
					// zero own tempo saturates the ramp high
					if (own == 0)
						q = 5000;
					else
						q = clamp_tempo((tgt * 20000 + own) / (2 * own) - 10000);
					r.ramp_wr = 1'b1;
					r.ramp = q[13:0];
					diff = own * (10000 + ct) - tgt * 10000;
					if (diff < 0)
						diff = -diff;
					if (diff < longint'(cfg.bpm_tolerance) * 10000) begin
						trk_mode = ST_LOCKED;
						trk_stable = '0;
					end
					bump_since_adjust();
				end
				ST_LOCKED: begin
					bump_since_adjust();
					if (trk_since_adjust >= cfg.check_interval) begin
						trk_since_adjust = '0;
						if (aph > lim) begin
							trk_mode = ST_DRIFT;
							trk_stable = '0;
						end else if (trk_stable != STAB_MAX) begin
							trk_stable++;
						end
					end
				end
				ST_DRIFT: begin
					bump_since_adjust();
					if (aph > lim) begin
						q = clamp_tempo(ct + ((ph > 0) ? 1 : -1));
						r.tempo_wr = 1'b1;
						r.tempo = q[13:0];
					end
					// phase exactly at the limit neither nudges nor relocks
					if (aph < lim && trk_since_adjust > cfg.settle_updates) begin
						trk_mode = ST_LOCKED;
						trk_stable = '0;
						trk_since_adjust = '0;
					end
				end
				default: ;
			endcase
		end
		r.state = trk_mode;
		r.locked = (trk_mode == ST_LOCKED) && (trk_stable >= cfg.stability_count);
		return r;
	endfunction

	function automatic void push_word(input logic [1:0] op, input logic present,
		input longint tgt, input longint own, input longint ct, input longint ph);
		sync_word_t w;
		w.op = op;
		w.present = present;
		w.tgt = tgt[16:0];
		w.own = own[16:0];
		w.ct = ct[13:0];
		w.ph = ph[23:0];
		pending_words.push_back(w);
		// reserved opcode words leave the sync state as it is but still return a result word; they don't count
		if (op != OP_RESERVED)
			words_queued++;
	endfunction

	function automatic longint pick_bpm();
		int sel;
		sel = $urandom_range(99);
		if (sel < 4)
			return 0;
		if (sel < 8)
			return 100000;
		return longint'($urandom_range(100000, 1));
	endfunction

	function automatic longint pick_tempo();
		return longint'($urandom_range(10000)) - 5000;
	endfunction

	function automatic longint pick_full_phase();
		return longint'($urandom_range(32'hFFFFFF)) - 8388608;
	endfunction

	// phase offsets clustered around the drift limit
	function automatic longint pick_phase();
		int sel;
		longint lim, v;
		lim = cfg.drift_limit;
		sel = $urandom_range(99);
		if (sel < 40)
			v = longint'($urandom_range(lim / 2));
		else if (sel < 50)
			v = lim;
		else if (sel < 88)
			v = lim + longint'($urandom_range(40, 1));
		else
			return pick_full_phase();
		return $urandom_range(1) ? -v : v;
	endfunction

	task automatic queue_random(input int n);
		int stop_at, k, n_init, n_run, sel;
		longint own, tgt, ct, ct_run, tol, jit;
		stop_at = words_queued + n;
		while (words_queued < stop_at) begin
			if ($urandom_range(99) < 20) begin
				for (k = 0; k < int'($urandom_range(3, 1)); k++)
					push_word(2'($urandom_range(3)), 1'($urandom_range(1)),
						longint'($urandom_range(100000)), longint'($urandom_range(100000)),
						pick_tempo(), pick_full_phase());
			end
			push_word(OP_ENABLE, 1'b1, longint'($urandom_range(100000)),
				longint'($urandom_range(100000)), pick_tempo(), pick_full_phase());
			own = pick_bpm();
			ct = pick_tempo();
			tgt = 0;
			tol = longint'(cfg.bpm_tolerance) * 10000;
			n_init = $urandom_range(4, 1);
			for (k = 0; k < n_init; k++) begin
				// last init update lands near lock so most sessions go on to track phase
				if (k == n_init - 1 || $urandom_range(1)) begin
					jit = longint'($urandom_range(2 * tol + 10000)) - tol - 5000;
					tgt = (own * (10000 + ct) + jit) / 10000;
				end else begin
					tgt = longint'($urandom_range(100000));
				end
				if (tgt < 0)
					tgt = 0;
				if (tgt > 100000)
					tgt = 100000;
				push_word(OP_UPDATE, 1'($urandom_range(1)), tgt, own, ct, pick_phase());
			end
			n_run = $urandom_range(30, 4);
			for (k = 0; k < n_run; k++) begin
				if ($urandom_range(9) == 0)
					ct_run = longint'($urandom_range(1) ? 5000 : -5000);
				else
					ct_run = clamp_tempo(ct + longint'($urandom_range(20)) - 10);
				push_word(OP_UPDATE, 1'($urandom_range(1)), tgt, own, ct_run, pick_phase());
			end
			sel = $urandom_range(99);
			if (sel < 60)
				push_word(OP_DISABLE, 1'($urandom_range(1)), tgt, own, ct, pick_phase());
			else if (sel < 75)
				push_word(OP_ENABLE, 1'b0, tgt, own, ct, pick_phase());
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CHECK_INTERVAL:  cfg.check_interval = value[19:0];
			REG_DRIFT_LIMIT:     cfg.drift_limit = value[15:0];
			REG_SETTLE_UPDATES:  cfg.settle_updates = value[15:0];
			REG_BPM_TOLERANCE:   cfg.bpm_tolerance = value[9:0];
			REG_STABILITY_COUNT: cfg.stability_count = value[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int ci, input int dl, input int su, input int tol,
		input int sc);
		write_reg(REG_CHECK_INTERVAL, ci);
		write_reg(REG_DRIFT_LIMIT, dl);
		write_reg(REG_SETTLE_UPDATES, su);
		write_reg(REG_BPM_TOLERANCE, tol);
		write_reg(REG_STABILITY_COUNT, sc);
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver: offers queued words, predicts each accepted one
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_sync_result(drive_word));
				words_accepted <= words_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_word = pending_words.pop_front();
					in_valid <= 1'b1;
					opcode <= drive_word.op;
					target_present <= drive_word.present;
					target_bpm <= drive_word.tgt;
					own_bpm <= drive_word.own;
					current_tempo <= drive_word.ct;
					phase_offset <= drive_word.ph;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each taken result word with the oldest prediction
	always @(posedge clk) begin
		sync_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("result word with nothing predicted: state %0d", sync_state);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.state !== sync_state || exp_r.locked !== is_locked ||
						exp_r.ramp_wr !== ramp_write || exp_r.ramp !== ramp_target ||
						exp_r.tempo_wr !== tempo_write || exp_r.tempo !== tempo_value) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display("mismatch: exp state %0d lock %0d ramp %0d/%0d tempo %0d/%0d",
								exp_r.state, exp_r.locked, exp_r.ramp_wr, exp_r.ramp,
								exp_r.tempo_wr, exp_r.tempo);
							$display("          got state %0d lock %0d ramp %0d/%0d tempo %0d/%0d",
								sync_state, is_locked, ramp_write, ramp_target,
								tempo_write, tempo_value);
						end
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one long receiver stall so the block backs up and drops in_ready
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && words_accepted >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 25;
		recv_idle_pct = 57;

		// reset register values
		push_word(OP_UPDATE, 1'b0, 12800, 12000, 0, 0);              // update while off
		push_word(OP_RESERVED, 1'b1, 100000, 100000, 5000, 8388607);
		push_word(OP_ENABLE, 1'b0, 0, 0, -5000, -8388608);           // no target deck
		push_word(OP_ENABLE, 1'b1, 100000, 100000, 0, 0);
		push_word(OP_UPDATE, 1'b0, 100000, 0, 0, 0);                 // zero own tempo
		push_word(OP_UPDATE, 1'b0, 100000, 1, 0, 0);                 // clamp high
		push_word(OP_UPDATE, 1'b0, 1, 100000, 0, 0);                 // clamp low
		push_word(OP_UPDATE, 1'b0, 0, 0, 0, 0);                      // locks on zero tempo
		push_word(OP_UPDATE, 1'b0, 0, 0, 0, 8388607);
		push_word(OP_DISABLE, 1'b0, 0, 0, 0, 0);
		wait_idle();

		// check on every update, tight limit
		set_config(0, 10, 2, 1000, 1);
		push_word(OP_ENABLE, 1'b1, 12600, 12000, 500, 0);
		push_word(OP_UPDATE, 1'b0, 12600, 12000, 500, 0);            // exact lock
		push_word(OP_UPDATE, 1'b0, 12600, 12000, 500, 10);           // at limit, stays
		push_word(OP_UPDATE, 1'b0, 12600, 12000, 500, -11);          // drift
		push_word(OP_UPDATE, 1'b0, 12600, 12000, 5000, 8388607);     // nudge clamps high
		push_word(OP_UPDATE, 1'b0, 12600, 12000, -5000, -8388608);   // nudge clamps low
		push_word(OP_UPDATE, 1'b0, 12600, 12000, 500, -10);          // at limit in drift
		push_word(OP_UPDATE, 1'b0, 12600, 12000, 500, 0);            // relock
		push_word(OP_UPDATE, 1'b0, 12600, 12000, 500, 3);
		push_word(OP_ENABLE, 1'b1, 12600, 12000, 500, 0);
		push_word(OP_DISABLE, 1'b1, 12600, 12000, 500, 0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				1: set_config(1, 0, 0, 1000, 0);
				3: set_config(1048575, 65535, 65535, 0, 65535);
				default: set_config($urandom_range(6, 1), $urandom_range(60),
					$urandom_range(10), $urandom_range(1000, 1), $urandom_range(4));
			endcase
			if (p < 2) begin
				send_idle_pct = 25;
				recv_idle_pct = 57;
			end else if (p < 4) begin
				send_idle_pct = 57;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			queue_random(PHASE_WORDS);
			wait_idle();
		end

		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
